@@ rtl/rrt_pkg.sv @@
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types and codes for the received range tracker: item modes, result
// status codes, and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int SEQ_W   = 32;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 2;
    localparam int SEG_W   = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_CLOSE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_INDEX = 2'd2;

    typedef enum logic [1:0] {
        RD_FIRST = 2'd0,
        RD_NEXT  = 2'd1,
        RD_IDX   = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic              cap;
        logic              open_set;
        logic              open_extend;
        logic              open_drop;
        logic              clear_all;
        logic              ptr_clr;
        logic              ptr_inc;
        logic              rd_en;
        rd_sel_t           rd_sel;
        logic              wr_merge;
        logic              wr_append;
        logic              resp;
        logic [STAT_W-1:0] resp_status;
        logic              resp_read;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  open_valid;
        logic  touch;
        logic  count_zero;
        logic  full;
        logic  idx_ok;
        logic  hit;
        logic  last;
    } sts_t;

endpackage

@@ rtl/rrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrt_ctrl
// Controller: decodes each item, sequences the table walk on a close or on an
// update that starts a new range, and issues the single response of the item.
// ----------------------------------------------------------------------------
module rrt_ctrl
    import rrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_WALK   = 5'b01000,
        S_TAIL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_FIRST;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.mode)
                    MODE_UPDATE, MODE_CLOSE:
                    begin
                        if (!sts.open_valid)
                        begin
                            // update opens a new range; close has nothing to do
                            cmd.open_set = (sts.mode == MODE_UPDATE);
                            cmd.resp     = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else if (sts.mode == MODE_UPDATE && sts.touch)
                        begin
                            cmd.open_extend = 1'b1;
                            cmd.resp        = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            cmd.ptr_clr = 1'b1;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_FIRST;
                            state_next  = S_WALK;
                        end
                    end
                    MODE_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.resp        = 1'b1;
                            cmd.resp_status = STATUS_INDEX;
                            state_next      = S_IDLE;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                        cmd.resp      = 1'b1;
                        state_next    = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.resp      = 1'b1;
                cmd.resp_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_WALK:
            begin
                if (sts.hit)
                begin
                    cmd.wr_merge  = 1'b1;
                    cmd.open_set  = (sts.mode == MODE_UPDATE);
                    cmd.open_drop = (sts.mode != MODE_UPDATE);
                    cmd.resp      = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (sts.last)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    // advance to the next entry while this one is compared
                    cmd.ptr_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = RD_NEXT;
                end
            end
            S_TAIL:
            begin
                cmd.wr_append   = !sts.full;
                cmd.resp_status = sts.full ? STATUS_FULL : STATUS_OK;
                cmd.open_set    = (sts.mode == MODE_UPDATE);
                cmd.open_drop   = (sts.mode != MODE_UPDATE);
                cmd.resp        = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rrt_datapath.sv @@
// ----------------------------------------------------------------------------
// rrt_datapath
// Datapath: open range registers, closed range table memory, walk pointer,
// merge compare and the registered result.
// ----------------------------------------------------------------------------
module rrt_datapath
    import rrt_pkg::*;
#(
    parameter int MAX_RANGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [MODE_W-1:0]  mode,
    input  logic [SEQ_W-1:0]   range_start,
    input  logic [SEQ_W-1:0]   range_end,
    input  logic [INDEX_W-1:0] entry_index,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [SEG_W-1:0]   segment_count,
    output logic [SEQ_W-1:0]   read_start,
    output logic [SEQ_W-1:0]   read_end
);

    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int EXT_W = (CNT_W > SEG_W) ? CNT_W : SEG_W;

    // captured item
    mode_t              mode_reg;
    logic [SEQ_W-1:0]   rs_reg;
    logic [SEQ_W-1:0]   re_reg;
    logic [INDEX_W-1:0] idx_reg;

    logic               open_valid_reg;
    logic [SEQ_W-1:0]   open_start_reg;
    logic [SEQ_W-1:0]   open_end_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   ptr_plus;

    logic [2*SEQ_W-1:0] mem [MAX_RANGES];
    logic [2*SEQ_W-1:0] rdata_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [2*SEQ_W-1:0] wr_data;
    logic               wr_en;

    logic [SEQ_W-1:0]   ent_start;
    logic [SEQ_W-1:0]   ent_end;
    logic               hit_inside;
    logic               hit_cover;
    logic [CMP_W-1:0]   idx_ext;
    logic [EXT_W-1:0]   count_ext;

    logic               done_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEQ_W-1:0]   rd_start_reg;
    logic [SEQ_W-1:0]   rd_end_reg;

    assign ptr_plus  = ptr_reg + CNT_W'(1);
    assign ent_start = rdata_reg[2*SEQ_W-1:SEQ_W];
    assign ent_end   = rdata_reg[SEQ_W-1:0];
    assign idx_ext   = CMP_W'(idx_reg);

    // start inside the entry, or the range reaching over the entry start
    assign hit_inside = (open_start_reg >= ent_start) && (open_start_reg <= ent_end);
    assign hit_cover  = (open_start_reg <= ent_start) && (open_end_reg >= ent_start);

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.open_valid = open_valid_reg;
        sts.touch      = ({1'b0, open_end_reg} + 33'd1) >= {1'b0, rs_reg};
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CNT_W'(MAX_RANGES));
        sts.idx_ok     = idx_ext < CMP_W'(count_reg);
        sts.hit        = hit_inside || hit_cover;
        sts.last       = (ptr_plus >= count_reg);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT: rd_addr = ptr_plus[IDX_W-1:0];
            RD_IDX:  rd_addr = idx_ext[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en = cmd.wr_merge || cmd.wr_append;
        if (cmd.wr_merge)
        begin
            wr_addr = ptr_reg[IDX_W-1:0];
            wr_data = {(hit_inside ? ent_start : open_start_reg),
                       ((open_end_reg > ent_end) ? open_end_reg : ent_end)};
        end
        else
        begin
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = {open_start_reg, open_end_reg};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_all)
        begin
            count_next = '0;
        end
        else if (cmd.wr_append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    assign count_ext = EXT_W'(count_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            mode_reg <= mode_t'(mode);
            rs_reg   <= range_start;
            re_reg   <= range_end;
            idx_reg  <= entry_index;
        end
        if (cmd.resp)
        begin
            status_reg   <= cmd.resp_status;
            seg_reg      <= count_ext[SEG_W-1:0];
            rd_start_reg <= cmd.resp_read ? ent_start : '0;
            rd_end_reg   <= cmd.resp_read ? ent_end : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_valid_reg <= 1'b0;
            open_start_reg <= '0;
            open_end_reg   <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg  <= cmd.resp;
            count_reg <= count_next;
            if (cmd.ptr_clr)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_plus;
            end
            if (cmd.clear_all)
            begin
                open_valid_reg <= 1'b0;
                open_start_reg <= '0;
                open_end_reg   <= '0;
            end
            else if (cmd.open_set)
            begin
                open_valid_reg <= 1'b1;
                open_start_reg <= rs_reg;
                open_end_reg   <= re_reg;
            end
            else if (cmd.open_drop)
            begin
                open_valid_reg <= 1'b0;
            end
            else if (cmd.open_extend && (re_reg > open_end_reg))
            begin
                open_end_reg <= re_reg;
            end
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign segment_count = seg_reg;
    assign read_start    = rd_start_reg;
    assign read_end      = rd_end_reg;

endmodule

@@ rtl/received_range_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// received_range_tracker_unit
// Tracks received sequence ranges: one open range plus a table of closed,
// coalesced ranges that can be read back by index.
//
//   channel   handshake          payload
//   command   start / busy       mode, range_start, range_end, entry_index
//   result    done (1 cycle)     status, segment_count, read_start, read_end
//
// A transfer is taken when start is high and busy is low; its result follows
// as a one-cycle done pulse. An update that opens or extends the open range,
// a clear, a close with no open range and a read past the count give their
// result from the decode state, and a read of a held entry from the read state
// once the table memory has been read. An update that starts a new range and
// a close of the open range walk the table memory one entry per cycle until
// the first overlap, else go to the tail state to append. Busy drops with the
// last cycle of an item, so the next transfer can be taken at the edge that
// takes the result. Reset empties the table and the open range at once; no
// clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module received_range_tracker_unit
    import rrt_pkg::*;
#(
    parameter int MAX_RANGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [MODE_W-1:0]  mode,
    input  logic [SEQ_W-1:0]   range_start,
    input  logic [SEQ_W-1:0]   range_end,
    input  logic [INDEX_W-1:0] entry_index,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [SEG_W-1:0]   segment_count,
    output logic [SEQ_W-1:0]   read_start,
    output logic [SEQ_W-1:0]   read_end
);

    cmd_t cmd;
    sts_t sts;

    rrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    rrt_datapath #(
        .MAX_RANGES (MAX_RANGES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .range_start   (range_start),
        .range_end     (range_end),
        .entry_index   (entry_index),
        .cmd           (cmd),
        .sts           (sts),
        .done          (done),
        .status        (status),
        .segment_count (segment_count),
        .read_start    (read_start),
        .read_end      (read_end)
    );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for received_range_tracker_unit. A directed script
// covers the edge cases of range tracking, then random traffic with bursts of
// disjoint updates fills the table. Each result is checked against the reply
// pinned to its script row, or else an in-bench copy of the tracker state.
// ----------------------------------------------------------------------------
module testbench;
    import rrt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int SCRIPT_ROWS = 22;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEG_W-1:0]  count;
        logic [SEQ_W-1:0]  lo;
        logic [SEQ_W-1:0]  hi;
    } tracker_reply_t;

    // One scripted command; a pinned row carries its reply written out by hand.
    typedef struct packed {
        mode_t              cmd;
        logic [SEQ_W-1:0]   lo;
        logic [SEQ_W-1:0]   hi;
        logic [INDEX_W-1:0] idx;
        logic               pinned;
        tracker_reply_t     reply;
    } probe_t;

    localparam probe_t SCRIPT [SCRIPT_ROWS] = '{
        '{MODE_READ,   32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_INDEX, 5'd0, 32'd0, 32'd0}},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_OK, 5'd0, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_OK, 5'd0, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd1,         32'd10,        4'd0,  1'b1,
          '{STATUS_OK, 5'd0, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd20,        32'd30,        4'd0,  1'b1,
          '{STATUS_OK, 5'd1, 32'd0, 32'd0}},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd25,        32'd40,        4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b0, '0},
        '{MODE_UPDATE, 32'd15,        32'd22,        4'd0,  1'b0, '0},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b0, '0},
        '{MODE_READ,   32'd0,         32'd0,         4'd1,  1'b0, '0},
        '{MODE_UPDATE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd0,         32'd5,         4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0,  1'b1,
          '{STATUS_OK, 5'd2, 32'd0, 32'd0}},
        '{MODE_CLOSE,  32'd0,         32'd0,         4'd0,  1'b0, '0},
        '{MODE_UPDATE, 32'd100,       32'd50,        4'd0,  1'b1,
          '{STATUS_OK, 5'd3, 32'd0, 32'd0}},
        '{MODE_UPDATE, 32'd200,       32'd300,       4'd0,  1'b0, '0},
        '{MODE_READ,   32'd0,         32'd0,         4'd15, 1'b1,
          '{STATUS_INDEX, 5'd4, 32'd0, 32'd0}},
        '{MODE_READ,   32'd0,         32'd0,         4'd3,  1'b0, '0},
        '{MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1,
          '{STATUS_OK, 5'd0, 32'd0, 32'd0}},
        '{MODE_READ,   32'd0,         32'd0,         4'd0,  1'b1,
          '{STATUS_INDEX, 5'd0, 32'd0, 32'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    mode_t mode;
    logic [SEQ_W-1:0] range_start;
    logic [SEQ_W-1:0] range_end;
    logic [INDEX_W-1:0] entry_index;
    logic done;
    logic [STAT_W-1:0] status;
    logic [SEG_W-1:0] segment_count;
    logic [SEQ_W-1:0] read_start;
    logic [SEQ_W-1:0] read_end;

    // Hand-written reply that travels with the command it belongs to
    logic pin_valid;
    tracker_reply_t pin_reply;

    // Tracker state mirrored in the bench
    logic open_valid;
    logic [SEQ_W-1:0] open_lo;
    logic [SEQ_W-1:0] open_hi;
    logic [SEQ_W-1:0] seg_lo [TABLE_DEPTH];
    logic [SEQ_W-1:0] seg_hi [TABLE_DEPTH];
    int unsigned seg_count;

    tracker_reply_t replies_due [$];
    int faults;
    int issued;
    int checked;
    int drops;
    int misses;
    int quiet_cycles;
    int gap_pct;
    int spray_left;
    logic [SEQ_W-1:0] cursor;

    received_range_tracker_unit #(
        .MAX_RANGES (TABLE_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .range_start   (range_start),
        .range_end     (range_end),
        .entry_index   (entry_index),
        .done          (done),
        .status        (status),
        .segment_count (segment_count),
        .read_start    (read_start),
        .read_end      (read_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Merge a closed range into the first overlapping entry, else append.
    // Returns 1 when the table is full and the range is dropped.
    function automatic bit file_range(logic [SEQ_W-1:0] cs, logic [SEQ_W-1:0] ce);
        for (int i = 0; i < seg_count; i++)
        begin
            if (cs >= seg_lo[i] && cs <= seg_hi[i])
            begin
                if (ce > seg_hi[i])
                    seg_hi[i] = ce;
                return 1'b0;
            end
            if (cs <= seg_lo[i] && ce >= seg_lo[i])
            begin
                seg_lo[i] = cs;
                if (ce > seg_hi[i])
                    seg_hi[i] = ce;
                return 1'b0;
            end
        end
        if (seg_count < TABLE_DEPTH)
        begin
            seg_lo[seg_count] = cs;
            seg_hi[seg_count] = ce;
            seg_count++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic tracker_reply_t track_cmd(mode_t cmd, logic [SEQ_W-1:0] lo,
                                                 logic [SEQ_W-1:0] hi,
                                                 logic [INDEX_W-1:0] idx);
        tracker_reply_t r;
        r = '0;
        case (cmd)
            MODE_UPDATE:
            begin
                if (!open_valid)
                begin
                    open_valid = 1'b1;
                    open_lo = lo;
                    open_hi = hi;
                end
                else if ({1'b0, open_hi} + 33'd1 >= {1'b0, lo})
                begin
                    if (hi > open_hi)
                        open_hi = hi;
                end
                else
                begin
                    if (file_range(open_lo, open_hi))
                        r.status = STATUS_FULL;
                    open_lo = lo;
                    open_hi = hi;
                end
            end
            MODE_CLOSE:
            begin
                if (open_valid)
                begin
                    if (file_range(open_lo, open_hi))
                        r.status = STATUS_FULL;
                    open_valid = 1'b0;
                end
            end
            MODE_READ:
            begin
                if (idx < seg_count)
                begin
                    r.lo = seg_lo[idx];
                    r.hi = seg_hi[idx];
                end
                else
                    r.status = STATUS_INDEX;
            end
            default:
            begin
                open_valid = 1'b0;
                open_lo = '0;
                open_hi = '0;
                seg_count = 0;
            end
        endcase
        r.count = seg_count[SEG_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : reply_check
        tracker_reply_t got;
        tracker_reply_t want;
        tracker_reply_t model;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{status, segment_count, read_start, read_end};
                if (replies_due.size() == 0)
                begin
                    faults++;
                    if (faults <= REPORT_LIMIT)
                        $display("%0t: result with none pending: status=%0d count=%0d %h..%h",
                                 $time, got.status, got.count, got.lo, got.hi);
                end
                else
                begin
                    want = replies_due.pop_front();
                    checked++;
                    if (got !== want)
                    begin
                        faults++;
                        if (faults <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: want status=%0d count=%0d %h..%h",
                                     $time, want.status, want.count, want.lo, want.hi);
                            $display("    got status=%0d count=%0d %h..%h",
                                     got.status, got.count, got.lo, got.hi);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                model = track_cmd(mode, range_start, range_end, entry_index);
                if (model.status == STATUS_FULL)
                    drops++;
                if (model.status == STATUS_INDEX)
                    misses++;
                replies_due.push_back(pin_valid ? pin_reply : model);
                issued++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hold the command until the transfer, then idle at random.
    task automatic issue(mode_t cmd, logic [SEQ_W-1:0] lo, logic [SEQ_W-1:0] hi,
                         logic [INDEX_W-1:0] idx, logic pinned, tracker_reply_t reply);
        start <= 1'b1;
        mode <= cmd;
        range_start <= lo;
        range_end <= hi;
        entry_index <= idx;
        pin_valid <= pinned;
        pin_reply <= reply;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending until every pending result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (replies_due.size() != 0);
        @(posedge clk);
    endtask

    task automatic random_phase(int n_items);
        mode_t cmd;
        logic [SEQ_W-1:0] lo;
        logic [SEQ_W-1:0] hi;
        logic [INDEX_W-1:0] idx;
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            lo = $urandom();
            hi = $urandom();
            idx = INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
            pick = $urandom_range(0, 199);
            cmd = MODE_UPDATE;
            if (spray_left > 0)
            begin
                // disjoint ascending ranges: every one closes the previous
                spray_left--;
                lo = cursor + $urandom_range(2, 100);
                hi = lo + $urandom_range(0, 30);
                cursor = hi;
            end
            else if (pick < 3)
            begin
                cmd = MODE_CLEAR;
                cursor = $urandom();
            end
            else if (pick < 50)
                cmd = MODE_CLOSE;
            else if (pick < 95)
                cmd = MODE_READ;
            else
            begin
                if (pick < 105)
                    spray_left = $urandom_range(17, 22);
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    lo = cursor + $urandom_range(0, 2);
                    hi = lo + $urandom_range(0, 20);
                end
                else if (pick < 55)
                begin
                    lo = cursor + $urandom_range(2, 200);
                    hi = lo + $urandom_range(0, 50);
                end
                else if (pick < 70)
                begin
                    lo = cursor - $urandom_range(0, 500);
                    hi = lo + $urandom_range(0, 600);
                end
                else if (pick < 78)
                begin
                    lo = cursor + $urandom_range(2, 100);
                    hi = lo - $urandom_range(1, 10);
                end
                else if (pick < 90)
                begin
                    lo = 32'hFFFF_FFFF - $urandom_range(0, 40);
                    hi = 32'hFFFF_FFFF - $urandom_range(0, 5);
                end
                cursor = hi;
            end
            issue(cmd, lo, hi, idx, 1'b0, '0);
            if ($urandom_range(0, 99) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_UPDATE;
        range_start = '0;
        range_end = '0;
        entry_index = '0;
        pin_valid = 1'b0;
        pin_reply = '0;
        open_valid = 1'b0;
        open_lo = '0;
        open_hi = '0;
        seg_count = 0;
        faults = 0;
        issued = 0;
        checked = 0;
        drops = 0;
        misses = 0;
        spray_left = 0;
        gap_pct = 26;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
            issue(SCRIPT[i].cmd, SCRIPT[i].lo, SCRIPT[i].hi, SCRIPT[i].idx,
                  SCRIPT[i].pinned, SCRIPT[i].reply);
        drain();

        cursor = $urandom();
        random_phase(170);
        drain();
        gap_pct = 78;
        random_phase(170);
        drain();
        gap_pct = 0;
        random_phase(170);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (replies_due.size() != 0)
        begin
            faults++;
            $display("%0d results never arrived", replies_due.size());
        end
        $display("Sent %0d commands and checked %0d results,", issued, checked);
        $display("with %0d ranges dropped on a full table and %0d reads past the count.",
                 drops, misses);
        if (faults == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rrt_pkg.sv
rtl/rrt_ctrl.sv
rtl/rrt_datapath.sv
rtl/received_range_tracker_unit.sv
test/testbench.sv
